// ===== hdl/decimal_string_to_u64_with_suffix_macros.svh =====
// Assertion macros for the decimal string converter.
`ifndef DECIMAL_STRING_TO_U64_WITH_SUFFIX_MACROS_SVH
`define DECIMAL_STRING_TO_U64_WITH_SUFFIX_MACROS_SVH

`ifndef SYNTH
`define DSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsu same-cycle check failed");
`define DSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsu next-cycle check failed");
`else
`define DSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define DSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/dsu_pkg.sv =====
package dsu_pkg;

	localparam int unsigned ValueWidth = 64;
	localparam int unsigned ShiftWidth = 7;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_K    = 8'h6B;
	localparam logic [7:0] CHAR_M    = 8'h4D;
	localparam logic [7:0] CHAR_G    = 8'h47;
	localparam logic [7:0] CHAR_T    = 8'h54;
	localparam logic [7:0] CHAR_P    = 8'h50;
	localparam logic [7:0] CHAR_E    = 8'h45;
	localparam logic [7:0] CHAR_Z    = 8'h5A;
	localparam logic [7:0] CHAR_Y    = 8'h59;

	localparam logic [ValueWidth-1:0] LIMIT_DIV_TEN = 64'h1999_9999_9999_9999;
	localparam logic [3:0]            LIMIT_REM_TEN = 4'd5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} char_item_t;

	typedef struct packed {
		logic                  emit;
		logic [ValueWidth-1:0] value;
		status_t               status;
	} result_t;

	// zero when the character is not a scale letter
	function automatic logic [ShiftWidth-1:0] suffix_shift(input logic [7:0] ch);
		logic [ShiftWidth-1:0] amt;
		case (ch)
			CHAR_K:  amt = 7'd10;
			CHAR_M:  amt = 7'd20;
			CHAR_G:  amt = 7'd30;
			CHAR_T:  amt = 7'd40;
			CHAR_P:  amt = 7'd50;
			CHAR_E:  amt = 7'd60;
			CHAR_Z:  amt = 7'd70;
			CHAR_Y:  amt = 7'd80;
			default: amt = 7'd0;
		endcase
		return amt;
	endfunction

endpackage

// ===== hdl/decimal_string_to_u64_with_suffix.sv =====
// channel   | handshake              | payload
// ----------+------------------------+----------------------------
// char in   | char_valid, char_stall | ch[7:0], first
// result    | res_valid, res_stall   | value[63:0], status[1:0]
// config    | cfg_valid, cfg_ready   | allow_suffix
//
// One character per cycle unless char_stall is high.
// Path: input register, parse logic with accumulator, result register.
// Reset clears the accumulator, sets allow_suffix and waits for a first item.
// A held result stalls input only when the next character also ends a string.
module decimal_string_to_u64_with_suffix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        allow_suffix,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  ch,
	input  logic        first,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [63:0] value,
	output logic [1:0]  status
);

	dsu_pkg::char_item_t item;
	dsu_pkg::char_item_t item_s1;
	dsu_pkg::result_t    res;
	logic                valid_s1;
	logic                out_ready;
	logic                fire;

	assign cfg_ready = 1'b1;
	assign item      = '{ch: ch, first: first};
	assign fire      = valid_s1 && (!res.emit || out_ready);

	dsu_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.item       (item),
		.take       (fire),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	dsu_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (allow_suffix),
		.item_s1  (item_s1),
		.fire     (fire),
		.res      (res)
	);

	dsu_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res.emit),
		.res       (res),
		.res_stall (res_stall),
		.ready     (out_ready),
		.res_valid (res_valid),
		.value     (value),
		.status    (status)
	);

endmodule

// ===== hdl/dsu_in_reg.sv =====
module dsu_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  dsu_pkg::char_item_t item,
	input  logic               take,
	output logic               valid_s1,
	output dsu_pkg::char_item_t item_s1
);

	logic load;

	assign char_stall = valid_s1 && !take;
	assign load       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== hdl/dsu_parse.sv =====
`include "decimal_string_to_u64_with_suffix_macros.svh"

module dsu_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_data,
	input  dsu_pkg::char_item_t item_s1,
	input  logic                fire,
	output dsu_pkg::result_t    res
);

	logic                                   allow_q;
	logic [dsu_pkg::ValueWidth-1:0]         acc_q;
	logic                                   fin_q;
	logic [dsu_pkg::ValueWidth-1:0]         eff_acc;
	logic                                   eff_fin;
	logic                                   is_digit;
	logic [3:0]                             digit;
	logic                                   fits;
	logic [dsu_pkg::ValueWidth-1:0]         mul;
	logic [dsu_pkg::ShiftWidth-1:0]         amt;
	logic                                   sfx_ok;
	logic                                   sfx_ovf;
	logic [dsu_pkg::ValueWidth-1:0]         acc_next;

	assign eff_acc  = item_s1.first ? '0 : acc_q;
	assign eff_fin  = item_s1.first ? 1'b0 : fin_q;
	assign is_digit = item_s1.ch inside {[dsu_pkg::CHAR_ZERO:dsu_pkg::CHAR_NINE]};
	assign digit    = 4'(item_s1.ch - dsu_pkg::CHAR_ZERO);
	assign fits     = (eff_acc < dsu_pkg::LIMIT_DIV_TEN) ||
		((eff_acc == dsu_pkg::LIMIT_DIV_TEN) && (digit <= dsu_pkg::LIMIT_REM_TEN));
	assign mul      = (eff_acc << 3) + (eff_acc << 1) + 64'(digit);
	assign amt      = dsu_pkg::suffix_shift(item_s1.ch);
	assign sfx_ok   = allow_q && (amt != '0);
	assign sfx_ovf  = (amt >= 7'(dsu_pkg::ValueWidth)) ||
		((eff_acc >> (7'(dsu_pkg::ValueWidth) - amt)) != '0);

	always_comb begin
		res = '{emit: 1'b0, value: '0, status: dsu_pkg::ST_OK};
		if (!eff_fin) begin
			if (is_digit) begin
				if (!fits) begin
					res.emit   = 1'b1;
					res.status = dsu_pkg::ST_OVERFLOW;
				end
			end else if (item_s1.ch == dsu_pkg::CHAR_NUL) begin
				res.emit  = 1'b1;
				res.value = eff_acc;
			end else if (!sfx_ok) begin
				res.emit   = 1'b1;
				res.status = dsu_pkg::ST_INVALID;
			end else if (eff_acc == '0) begin
				res.emit = 1'b1;
			end else if (sfx_ovf) begin
				res.emit   = 1'b1;
				res.status = dsu_pkg::ST_OVERFLOW;
			end else begin
				res.emit  = 1'b1;
				res.value = eff_acc << amt[5:0];
			end
		end
	end

	assign acc_next = (!eff_fin && is_digit && fits) ? mul : eff_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b1;
			acc_q   <= '0;
			fin_q   <= 1'b1;
		end else begin
			if (cfg_we) begin
				allow_q <= cfg_data;
			end
			if (fire) begin
				acc_q <= acc_next;
				fin_q <= res.emit ? 1'b1 : eff_fin;
			end
		end
	end

	`DSU_ASSERT_NEXT(a_emit_goes_idle, clk, arst_n, fire && res.emit, fin_q)
	`DSU_ASSERT_SAME(a_idle_is_silent, clk, arst_n, fin_q && !item_s1.first, !res.emit)
	`DSU_ASSERT_SAME(a_error_zero_value, clk, arst_n,
		res.emit && (res.status != dsu_pkg::ST_OK), res.value == '0)

endmodule

// ===== hdl/dsu_out_reg.sv =====
module dsu_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  dsu_pkg::result_t               res,
	input  logic                           res_stall,
	output logic                           ready,
	output logic                           res_valid,
	output logic [dsu_pkg::ValueWidth-1:0] value,
	output logic [1:0]                     status
);

	logic                           res_valid_q;
	logic [dsu_pkg::ValueWidth-1:0] value_q;
	dsu_pkg::status_t               status_q;

	assign ready     = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= res.value;
			status_q <= res.status;
		end
	end

endmodule

// ===== tb/tb_decimal_string_to_u64_with_suffix.sv =====
`timescale 1ns / 100ps

module tb_decimal_string_to_u64_with_suffix;

	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_CHARS   = 110;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [63:0]      value;
		dsu_pkg::status_t status;
	} conversion_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        allow_suffix;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  ch;
	logic        first;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [63:0] value;
	logic [1:0]  status;

	logic [7:0] scale_letters [8] = '{dsu_pkg::CHAR_K, dsu_pkg::CHAR_M,
		dsu_pkg::CHAR_G, dsu_pkg::CHAR_T, dsu_pkg::CHAR_P, dsu_pkg::CHAR_E,
		dsu_pkg::CHAR_Z, dsu_pkg::CHAR_Y};

	// converter state as seen from outside
	logic [63:0] acc_reg       = '0;
	bit          waiting_first = 1'b1;
	bit          suffix_on     = 1'b1;

	conversion_t         conv_q [$];
	dsu_pkg::char_item_t text_q [$];

	int mismatches   = 0;
	int parsed_chars = 0;
	int ok_count     = 0;
	int bad_count    = 0;
	int ovf_count    = 0;
	int burst_left   = 0;
	bit steady_send  = 1'b0;
	bit hold_req     = 1'b0;
	int idle_cycles  = 0;

	decimal_string_to_u64_with_suffix u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.allow_suffix (allow_suffix),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.ch           (ch),
		.first        (first),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.value        (value),
		.status       (status)
	);

	always #2 clk = ~clk;

	function automatic int scale_shift(input logic [7:0] c);
		for (int i = 0; i < 8; i++) begin
			if (scale_letters[i] == c) begin
				return 10 * (i + 1);
			end
		end
		return 0;
	endfunction

	function automatic void finish_string(input logic [63:0] v, input dsu_pkg::status_t st);
		conversion_t res;
		res.value = v;
		res.status = st;
		conv_q.push_back(res);
		waiting_first = 1'b1;
	endfunction

	task automatic parse_char(input logic [7:0] c, input logic f, output bit took);
		logic [3:0] d;
		int sh;
		if (f) begin
			acc_reg = '0;
			waiting_first = 1'b0;
		end
		took = !waiting_first;
		if (waiting_first) begin
			return;
		end
		if (c >= dsu_pkg::CHAR_ZERO && c <= dsu_pkg::CHAR_NINE) begin
			d = 4'(c - dsu_pkg::CHAR_ZERO);
			if (acc_reg < dsu_pkg::LIMIT_DIV_TEN ||
					(acc_reg == dsu_pkg::LIMIT_DIV_TEN && d <= dsu_pkg::LIMIT_REM_TEN)) begin
				acc_reg = acc_reg * 64'd10 + 64'(d);
			end else begin
				finish_string('0, dsu_pkg::ST_OVERFLOW);
			end
		end else if (c == dsu_pkg::CHAR_NUL) begin
			finish_string(acc_reg, dsu_pkg::ST_OK);
		end else begin
			sh = suffix_on ? scale_shift(c) : 0;
			if (sh == 0) begin
				finish_string('0, dsu_pkg::ST_INVALID);
			end else if (acc_reg == '0) begin
				finish_string('0, dsu_pkg::ST_OK);
			end else if (sh >= 64 || acc_reg > (ALL_ONES >> sh)) begin
				finish_string('0, dsu_pkg::ST_OVERFLOW);
			end else begin
				finish_string(acc_reg << sh, dsu_pkg::ST_OK);
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	// call right after a falling edge
	task automatic send_char(input logic [7:0] c, input logic f);
		bit took;
		char_valid <= 1'b1;
		ch <= c;
		first <= f;
		do @(posedge clk); while (char_stall);
		parse_char(c, f, took);
		if (took) begin
			parsed_chars++;
		end
		@(negedge clk);
		if (!steady_send) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 16);
				char_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_text(input string s, input bit nul_end);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == 0);
		end
		if (nul_end) begin
			send_char(dsu_pkg::CHAR_NUL, s.len() == 0);
		end
	endtask

	task automatic send_queued();
		while (text_q.size() != 0) begin
			dsu_pkg::char_item_t it;
			it = text_q.pop_front();
			send_char(it.ch, it.first);
		end
	endtask

	task automatic wait_for_results();
		char_valid <= 1'b0;
		while (conv_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_allow_suffix(input bit on);
		cfg_valid <= 1'b1;
		allow_suffix <= on;
		do @(posedge clk); while (!cfg_ready);
		suffix_on = on;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void queue_text(input string s);
		dsu_pkg::char_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.ch = s[i];
			it.first = (text_q.size() == 0);
			text_q.push_back(it);
		end
	endfunction

	function automatic void queue_char(input logic [7:0] c, input logic f);
		dsu_pkg::char_item_t it;
		it.ch = c;
		it.first = f;
		text_q.push_back(it);
	endfunction

	function automatic void queue_number();
		logic [63:0] v;
		if ($urandom_range(0, 9) == 0) begin
			queue_text("00");
		end
		case ($urandom_range(0, 4))
			0: v = 64'($urandom_range(0, 9999));
			1: v = {$urandom, $urandom};
			2: v = ALL_ONES - 64'($urandom_range(0, 20));
			3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: v = 64'($urandom_range(0, 9));
		endcase
		if ($urandom_range(0, 9) != 0) begin
			queue_text($sformatf("%0d", v));
		end
	endfunction

	function automatic void queue_random_string();
		logic [7:0] c;
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			queue_number();
			if ($urandom_range(0, 1) == 0) begin
				queue_char(dsu_pkg::CHAR_NUL, text_q.size() == 0);
			end else begin
				queue_char(scale_letters[$urandom_range(0, 7)], text_q.size() == 0);
			end
			if ($urandom_range(0, 9) < 3) begin
				repeat ($urandom_range(1, 3)) queue_char(8'($urandom_range(0, 255)), 1'b0);
			end
		end else if (kind < 67) begin
			queue_number();
			do c = 8'($urandom_range(0, 255));
			while (c == dsu_pkg::CHAR_NUL ||
				(c >= dsu_pkg::CHAR_ZERO && c <= dsu_pkg::CHAR_NINE));
			queue_char(c, text_q.size() == 0);
		end else if (kind < 77) begin
			queue_number();
		end else if (kind < 87) begin
			if ($urandom_range(0, 1) == 0) begin
				queue_text($sformatf("18446744073709551%03d", $urandom_range(0, 999)));
			end else begin
				queue_text($sformatf("%0d%0d", {$urandom, $urandom}, $urandom_range(10, 99)));
			end
			queue_char(dsu_pkg::CHAR_NUL, 1'b0);
		end else if (kind < 93) begin
			repeat ($urandom_range(1, 4)) queue_char(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			repeat ($urandom_range(1, 4)) begin
				queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endfunction

	always @(posedge clk) begin : check_results
		conversion_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (conv_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d status=%0d",
					value, status));
			end else begin
				want = conv_q.pop_front();
				if (value !== want.value) begin
					report_mismatch($sformatf("value %0d, want %0d", value, want.value));
				end
				if (status !== want.status) begin
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				end
				case (want.status)
					dsu_pkg::ST_OK:      ok_count++;
					dsu_pkg::ST_INVALID: bad_count++;
					default:             ovf_count++;
				endcase
			end
		end
	end

	always @(negedge clk) begin : drive_res_stall
		static int hold_left = 0;
		static int phase_left = 0;
		static int stall_mode = 0;
		static logic [7:0] pattern = '0;
		static int beat = 0;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		beat++;
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			if (phase_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 200);
				pattern = 8'($urandom);
			end
			phase_left--;
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 3) == 0);
				2: res_stall <= pattern[beat % 8];
				default: res_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)
				|| !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic test_special_cases();
		send_text("", 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("0Y", 1'b0);
		send_text("7E", 1'b0);
		send_text("3kx", 1'b0);
		send_char("A", 1'b0);
		send_text("12", 1'b0);
		send_text("5", 1'b1);
		send_text("9/", 1'b0);
		send_text("4:", 1'b0);
	endtask

	task automatic test_scale_letters();
		for (int i = 0; i < 8; i++) begin
			send_char("1", 1'b1);
			send_char(scale_letters[i], 1'b0);
		end
		send_text("16E", 1'b0);
	endtask

	task automatic test_digit_limits();
		send_text("18446744073709551615", 1'b1);
		send_text("18446744073709551616", 1'b1);
		send_text("18446744073709551620", 1'b1);
	endtask

	task automatic test_plain_mode();
		send_text("5k", 1'b0);
		send_text("0Y", 1'b0);
		send_text("42", 1'b1);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		steady_send = 1'b1;
		for (int i = 0; i < 30; i++) begin
			send_text($sformatf("%0d", $urandom_range(0, 9)), 1'b1);
		end
		steady_send = 1'b0;
	endtask

	task automatic test_random_strings();
		int target;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_allow_suffix(p < 2 ? p[0] : 1'($urandom_range(0, 1)));
			target = parsed_chars + PHASE_CHARS;
			while (parsed_chars < target) begin
				queue_random_string();
				send_queued();
			end
			wait_for_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		allow_suffix = 1'b1;
		char_valid = 1'b0;
		ch = '0;
		first = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_special_cases();
		test_scale_letters();
		test_digit_limits();
		wait_for_results();
		write_allow_suffix(1'b0);
		test_plain_mode();
		wait_for_results();
		write_allow_suffix(1'b1);
		test_backpressure();
		wait_for_results();
		test_random_strings();

		$display("Parsed %0d characters into %0d results: %0d ok, %0d invalid, %0d overflow.",
			parsed_chars, ok_count + bad_count + ovf_count, ok_count, bad_count, ovf_count);
		$display("Suffix mode on and off, long output hold-off, bursty input, %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
